@@ design/rbs_pkg.sv @@
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared widths, types and constants for the ray / box slab intersector.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;

    localparam int NAXIS = 3;
    localparam int NLANE = 2 * NAXIS;

    // numerator of one slab distance: corner - start
    localparam int NW = COORD_WIDTH + 1;
    // dividend / quotient of one slab distance: numerator << FRAC_BITS
    localparam int QW = NW + FRAC_BITS;
    // divisor magnitude and remainder
    localparam int DW = COORD_WIDTH;
    // signed ray parameter, with room for the infinite-slab marks
    localparam int TW = QW + 2;
    // quotient bits, one per cell
    localparam int NCELL = QW;

    // split of t for the two partial products of the hit point
    localparam int TLO = QW / 2;
    localparam int THI = QW - TLO;
    localparam int PLW = DW + TLO;
    localparam int PHW = DW + THI;
    localparam int PW  = DW + QW;
    // offset magnitude kept for the hit point; anything larger saturates
    localparam int SW  = COORD_WIDTH + 1;

    localparam logic signed [TW-1:0] T_INF = TW'(1) << (TW - 2);
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t dir_x;
        coord_t dir_y;
        coord_t dir_z;
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } ray_t;

    typedef struct packed {
        logic [QW-1:0] w;   // dividend bits still to use, quotient bits shifted in
        logic [DW-1:0] r;   // partial remainder
        logic [DW-1:0] d;   // divisor magnitude
    } lane_t;

    typedef lane_t [NLANE-1:0] lanes_t;

    typedef struct packed {
        logic [NAXIS-1:0][COORD_WIDTH-1:0] start;
        logic [NAXIS-1:0][DW-1:0]          dmag;
        logic [NAXIS-1:0]                  dneg;
        logic [NAXIS-1:0]                  dzero;
        logic [NLANE-1:0]                  qneg;
        logic                              slab_miss;
    } side_t;

endpackage

`default_nettype wire

@@ design/rbs_if.sv @@
// ----------------------------------------------------------------------------
// rbs_ray_if / rbs_res_if
// Valid/ready channels for ray words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbs_ray_if;
    import rbs_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;

    modport source (
        output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface rbs_res_if;
    import rbs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [COORD_WIDTH-2:0] hit_distance;
    coord_t                 point_x;
    coord_t                 point_y;
    coord_t                 point_z;

    modport source (
        output valid, hit, hit_distance, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_distance, point_x, point_y, point_z,
        output ready
    );
endinterface

`default_nettype wire

@@ design/rbs_prep.sv @@
// ----------------------------------------------------------------------------
// rbs_prep
// Entry stage: slab numerators, divisor magnitudes, signs and the
// zero-direction bounds check.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_prep (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire rbs_pkg::ray_t in_ray,
    output logic               out_valid,
    output rbs_pkg::lanes_t    out_lanes,
    output rbs_pkg::side_t     out_side
);
    import rbs_pkg::*;

    coord_t s [NAXIS];
    coord_t d [NAXIS];
    coord_t mn [NAXIS];
    coord_t mx [NAXIS];

    logic          valid_reg;
    lanes_t        lanes_reg, lanes_next;
    side_t         side_reg, side_next;

    always_comb
    begin
        logic signed [NW-1:0] diff;
        logic [NW-1:0]        nmag;
        logic [DW-1:0]        dm;
        coord_t               lo_c;
        coord_t               hi_c;
        s[0] = in_ray.start_x;    s[1] = in_ray.start_y;    s[2] = in_ray.start_z;
        d[0] = in_ray.dir_x;      d[1] = in_ray.dir_y;      d[2] = in_ray.dir_z;
        mn[0] = in_ray.box_min_x; mn[1] = in_ray.box_min_y; mn[2] = in_ray.box_min_z;
        mx[0] = in_ray.box_max_x; mx[1] = in_ray.box_max_y; mx[2] = in_ray.box_max_z;
        lanes_next = '0;
        side_next  = '0;
        for (int k = 0; k < NAXIS; k++)
        begin
            dm = d[k][DW-1] ? DW'(-d[k]) : DW'(d[k]);
            side_next.start[k] = s[k];
            side_next.dmag[k]  = dm;
            side_next.dneg[k]  = d[k][DW-1];
            side_next.dzero[k] = (d[k] == '0);
            for (int j = 0; j < 2; j++)
            begin
                diff = (j == 0) ? (NW'(mn[k]) - NW'(s[k])) : (NW'(mx[k]) - NW'(s[k]));
                nmag = diff[NW-1] ? NW'(-diff) : NW'(diff);
                lanes_next[2*k+j].w = {nmag, {FRAC_BITS{1'b0}}};
                lanes_next[2*k+j].r = '0;
                lanes_next[2*k+j].d = dm;
                side_next.qneg[2*k+j] = diff[NW-1] ^ d[k][DW-1];
            end
            // zero direction: slab is infinite when start lies between the corners
            lo_c = (mn[k] < mx[k]) ? mn[k] : mx[k];
            hi_c = (mn[k] < mx[k]) ? mx[k] : mn[k];
            if (side_next.dzero[k] && ((s[k] < lo_c) || (s[k] > hi_c)))
            begin
                side_next.slab_miss = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
            side_reg  <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

@@ design/rbs_cell.sv @@
// ----------------------------------------------------------------------------
// rbs_cell
// One restoring-division step: one quotient bit for each of the six slab
// divisions, with the word's side data riding along.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire rbs_pkg::lanes_t in_lanes,
    input  wire rbs_pkg::side_t  in_side,
    output logic                 out_valid,
    output rbs_pkg::lanes_t      out_lanes,
    output rbs_pkg::side_t       out_side
);
    import rbs_pkg::*;

    logic   valid_reg;
    lanes_t lanes_reg, lanes_next;
    side_t  side_reg;

    always_comb
    begin
        logic [DW:0] rs;
        logic        ge;
        for (int l = 0; l < NLANE; l++)
        begin
            rs = {in_lanes[l].r, in_lanes[l].w[QW-1]};
            ge = (rs >= {1'b0, in_lanes[l].d});
            lanes_next[l].d = in_lanes[l].d;
            lanes_next[l].r = ge ? DW'(rs - {1'b0, in_lanes[l].d}) : DW'(rs);
            // shift the used dividend bit out, the quotient bit in
            lanes_next[l].w = {in_lanes[l].w[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

@@ design/rbs_resolve.sv @@
// ----------------------------------------------------------------------------
// rbs_resolve
// Back end: signs the quotients, orders and narrows the slab intervals,
// picks t and forms the saturated hit point in six stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_resolve (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire rbs_pkg::lanes_t in_lanes,
    input  wire rbs_pkg::side_t  in_side,
    output logic                 out_valid,
    output logic                 out_hit,
    output logic [rbs_pkg::COORD_WIDTH-2:0] out_dist,
    output rbs_pkg::coord_t      out_point [rbs_pkg::NAXIS]
);
    import rbs_pkg::*;

    // stage A: ordered per-axis interval
    logic                   a_valid_reg;
    logic signed [TW-1:0]   a_lo_reg [NAXIS], a_lo_next [NAXIS];
    logic signed [TW-1:0]   a_hi_reg [NAXIS], a_hi_next [NAXIS];
    side_t                  a_side_reg;
    // stage B: narrowed interval
    logic                   b_valid_reg;
    logic signed [TW-1:0]   b_lo_reg, b_lo_next;
    logic signed [TW-1:0]   b_hi_reg, b_hi_next;
    side_t                  b_side_reg;
    // stage C: chosen t
    logic                   c_valid_reg;
    logic                   c_hit_reg, c_hit_next;
    logic [QW-1:0]          c_t_reg, c_t_next;
    logic [COORD_WIDTH-2:0] c_dist_reg, c_dist_next;
    side_t                  c_side_reg;
    // stage D: partial products
    logic                   d_valid_reg;
    logic                   d_hit_reg;
    logic [COORD_WIDTH-2:0] d_dist_reg;
    logic [PLW-1:0]         d_plo_reg [NAXIS];
    logic [PHW-1:0]         d_phi_reg [NAXIS];
    side_t                  d_side_reg;
    // stage E: offset magnitude
    logic                   e_valid_reg;
    logic                   e_hit_reg;
    logic [COORD_WIDTH-2:0] e_dist_reg;
    logic [SW-1:0]          e_m_reg [NAXIS], e_m_next [NAXIS];
    side_t                  e_side_reg;
    // stage F: output word
    logic                   f_valid_reg;
    logic                   f_hit_reg;
    logic [COORD_WIDTH-2:0] f_dist_reg;
    coord_t                 f_point_reg [NAXIS], f_point_next [NAXIS];

    always_comb
    begin
        logic signed [TW-1:0] tq [NLANE];
        for (int l = 0; l < NLANE; l++)
        begin
            tq[l] = $signed({2'b00, in_lanes[l].w});
            if (in_side.qneg[l])
            begin
                tq[l] = -tq[l];
            end
        end
        for (int k = 0; k < NAXIS; k++)
        begin
            if (in_side.dzero[k])
            begin
                a_lo_next[k] = -T_INF;
                a_hi_next[k] = T_INF;
            end
            else if (tq[2*k] < tq[2*k+1])
            begin
                a_lo_next[k] = tq[2*k];
                a_hi_next[k] = tq[2*k+1];
            end
            else
            begin
                a_lo_next[k] = tq[2*k+1];
                a_hi_next[k] = tq[2*k];
            end
        end
    end

    always_comb
    begin
        b_lo_next = a_lo_reg[0];
        b_hi_next = a_hi_reg[0];
        for (int k = 1; k < NAXIS; k++)
        begin
            if (a_lo_reg[k] > b_lo_next)
            begin
                b_lo_next = a_lo_reg[k];
            end
            if (a_hi_reg[k] < b_hi_next)
            begin
                b_hi_next = a_hi_reg[k];
            end
        end
    end

    always_comb
    begin
        logic signed [TW-1:0] t;
        t = b_lo_reg[TW-1] ? b_hi_reg : b_lo_reg;
        c_hit_next = !b_side_reg.slab_miss && (b_lo_reg <= b_hi_reg) && !t[TW-1];
        c_t_next   = t[QW-1:0];
        c_dist_next = (|t[TW-2:COORD_WIDTH-1]) ? {(COORD_WIDTH-1){1'b1}}
                                               : t[COORD_WIDTH-2:0];
    end

    always_comb
    begin
        logic [PW-1:0] m_full;
        for (int k = 0; k < NAXIS; k++)
        begin
            m_full = (PW'(d_phi_reg[k]) << TLO) + PW'(d_plo_reg[k]);
            // any offset past the kept width saturates the point anyway
            e_m_next[k] = (|m_full[PW-1:FRAC_BITS+SW]) ? {SW{1'b1}}
                                                        : m_full[FRAC_BITS+SW-1:FRAC_BITS];
        end
    end

    always_comb
    begin
        logic signed [SW:0] p;
        for (int k = 0; k < NAXIS; k++)
        begin
            p = e_side_reg.dneg[k]
                ? ((SW+1)'($signed(e_side_reg.start[k])) - $signed({1'b0, e_m_reg[k]}))
                : ((SW+1)'($signed(e_side_reg.start[k])) + $signed({1'b0, e_m_reg[k]}));
            if (!e_hit_reg)
            begin
                f_point_next[k] = '0;
            end
            else if (p > (SW+1)'(C_MAX))
            begin
                f_point_next[k] = C_MAX;
            end
            else if (p < (SW+1)'(C_MIN))
            begin
                f_point_next[k] = C_MIN;
            end
            else
            begin
                f_point_next[k] = p[COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_lo_reg   <= a_lo_next;
            a_hi_reg   <= a_hi_next;
            a_side_reg <= in_side;

            b_lo_reg   <= b_lo_next;
            b_hi_reg   <= b_hi_next;
            b_side_reg <= a_side_reg;

            c_hit_reg  <= c_hit_next;
            c_t_reg    <= c_t_next;
            c_dist_reg <= c_dist_next;
            c_side_reg <= b_side_reg;

            d_hit_reg  <= c_hit_reg;
            d_dist_reg <= c_hit_reg ? c_dist_reg : '0;
            d_side_reg <= c_side_reg;
            for (int k = 0; k < NAXIS; k++)
            begin
                d_plo_reg[k] <= PLW'(c_side_reg.dmag[k]) * PLW'(c_t_reg[TLO-1:0]);
                d_phi_reg[k] <= PHW'(c_side_reg.dmag[k]) * PHW'(c_t_reg[QW-1:TLO]);
            end

            e_hit_reg  <= d_hit_reg;
            e_dist_reg <= d_dist_reg;
            e_m_reg    <= e_m_next;
            e_side_reg <= d_side_reg;

            f_hit_reg   <= e_hit_reg;
            f_dist_reg  <= e_dist_reg;
            f_point_reg <= f_point_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_hit   = f_hit_reg;
    assign out_dist  = f_dist_reg;
    assign out_point = f_point_reg;

endmodule

`default_nettype wire

@@ design/ray_box_slab_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Fixed-point ray / axis-aligned box slab test with hit distance and point.
// ----------------------------------------------------------------------------
//   channel | dir | content
//   ray     | in  | start, direction, box corners (signed Q16.16)
//   res     | out | hit, hit_distance, point_x/y/z
//
// One word enters per cycle unless res stalls; a result leaves once its word
// has passed one entry stage, 49 division cells (one quotient bit each) and
// six back-end stages. The whole pipe advances together whenever
// the output register is empty or being taken, so a stall at res holds ray.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect (
    input  wire logic clk,
    input  wire logic rst_n,
    rbs_ray_if.sink   ray,
    rbs_res_if.source res
);
    import rbs_pkg::*;

    logic   en;
    ray_t   ray_word;
    logic   chain_valid [NCELL+1];
    lanes_t chain_lanes [NCELL+1];
    side_t  chain_side  [NCELL+1];
    coord_t point [NAXIS];

    assign en        = !res.valid || res.ready;
    assign ray.ready = en;

    assign ray_word.start_x   = ray.start_x;
    assign ray_word.start_y   = ray.start_y;
    assign ray_word.start_z   = ray.start_z;
    assign ray_word.dir_x     = ray.dir_x;
    assign ray_word.dir_y     = ray.dir_y;
    assign ray_word.dir_z     = ray.dir_z;
    assign ray_word.box_min_x = ray.box_min_x;
    assign ray_word.box_min_y = ray.box_min_y;
    assign ray_word.box_min_z = ray.box_min_z;
    assign ray_word.box_max_x = ray.box_max_x;
    assign ray_word.box_max_y = ray.box_max_y;
    assign ray_word.box_max_z = ray.box_max_z;

    rbs_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ray.valid),
        .in_ray    (ray_word),
        .out_valid (chain_valid[0]),
        .out_lanes (chain_lanes[0]),
        .out_side  (chain_side[0])
    );

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        rbs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_lanes  (chain_lanes[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_lanes (chain_lanes[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    rbs_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[NCELL]),
        .in_lanes  (chain_lanes[NCELL]),
        .in_side   (chain_side[NCELL]),
        .out_valid (res.valid),
        .out_hit   (res.hit),
        .out_dist  (res.hit_distance),
        .out_point (point)
    );

    assign res.point_x = point[0];
    assign res.point_y = point[1];
    assign res.point_z = point[2];

endmodule

`default_nettype wire
